// ===== hw/rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic res_last;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/deq_datapath.sv =====
// Queue pointers, ring storage and result register.
`timescale 1ns / 1ps
module deq_datapath #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [deq_pkg::OP_W-1:0]      op_in,
  input  logic [deq_pkg::DATA_W-1:0]    value_in,
  input  deq_pkg::ctl_cmd_t             cmd,
  output deq_pkg::ctl_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [deq_pkg::STATUS_W-1:0]  out_status,
  output logic [deq_pkg::DATA_W-1:0]    out_value,
  output logic                          out_last,
  output logic                          out_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [deq_pkg::OP_W-1:0]     op_q;
  logic [VALUE_BITS-1:0]        val_q;
  logic [VALUE_BITS-1:0]        val_ext;
  logic [AW-1:0]                front, front_next;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                list_idx;
  logic [CW-1:0]                list_idx_inc;
  logic [deq_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic                         res_ram, res_ram_next;
  logic                         res_list, res_list_next;
  logic                         is_empty, is_full;
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [VALUE_BITS-1:0]        rd_data;
  logic [deq_pkg::DATA_W-1:0]   rd_out;
  logic [AW-1:0]                front_dec;

  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  generate
    if (VALUE_BITS <= deq_pkg::DATA_W) begin : g_in_narrow
      assign val_ext = value_in[VALUE_BITS-1:0];
    end else begin : g_in_wide
      assign val_ext = {{(VALUE_BITS-deq_pkg::DATA_W){value_in[deq_pkg::DATA_W-1]}}, value_in};
    end
    if (VALUE_BITS >= deq_pkg::DATA_W) begin : g_out_wide
      assign rd_out = rd_data[deq_pkg::DATA_W-1:0];
    end else begin : g_out_narrow
      assign rd_out = {{(deq_pkg::DATA_W-VALUE_BITS){1'b0}}, rd_data};
    end
  endgenerate

  assign is_empty     = (count == '0);
  assign is_full      = (count == CW'(DEPTH));
  assign front_dec    = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign list_idx_inc = list_idx + 1'b1;

  assign sts.out_free = !out_valid || out_ready;
  assign sts.res_last = !res_list || (list_idx_inc == count);

  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = front;
    rd_en           = 1'b0;
    rd_addr         = ring_at(front, list_idx_inc);
    front_next      = front;
    count_next      = count;
    res_status_next = deq_pkg::STATUS_OK;
    res_ram_next    = 1'b0;
    res_list_next   = 1'b0;
    if (cmd.exec) begin
      case (op_q)
        deq_pkg::OP_PUSH_FRONT,
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            res_status_next = deq_pkg::STATUS_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
            if (op_q == deq_pkg::OP_PUSH_FRONT) begin
              wr_addr    = front_dec;
              front_next = front_dec;
            end else begin
              wr_addr = ring_at(front, count);
            end
          end
        end
        deq_pkg::OP_POP_FRONT,
        deq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            res_status_next = deq_pkg::STATUS_EMPTY;
          end else begin
            rd_en        = 1'b1;
            res_ram_next = 1'b1;
            count_next   = count - 1'b1;
            if (op_q == deq_pkg::OP_POP_FRONT) begin
              rd_addr    = front;
              front_next = ring_at(front, CW'(1));
            end else begin
              rd_addr = ring_at(front, count - 1'b1);
            end
          end
        end
        deq_pkg::OP_LIST: begin
          if (is_empty) begin
            res_status_next = deq_pkg::STATUS_EMPTY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = front;
            res_ram_next  = 1'b1;
            res_list_next = 1'b1;
          end
        end
        deq_pkg::OP_CLEAR: begin
          count_next = '0;
          front_next = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.load && res_list && !sts.res_last) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      res_list  <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      if (cmd.exec) begin
        res_list <= res_list_next;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= op_in;
      val_q <= val_ext;
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
      res_ram    <= res_ram_next;
      list_idx   <= '0;
    end else if (cmd.load && res_list && !sts.res_last) begin
      list_idx <= list_idx_inc;
    end
    if (cmd.load) begin
      out_status <= res_status;
      out_value  <= res_ram ? rd_out : '0;
      out_last   <= sts.res_last;
      out_empty  <= is_empty;
    end
  end

  deq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller state machine sequencing accept, execute and result load.
`timescale 1ns / 1ps
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::ctl_sts_t sts,
  output deq_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.res_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue: top level joining controller and datapath.
// Flow: an accepted input beat is latched, executed, then loaded as a result beat.
// A new item is taken only when the last is done; a list emits one word per cycle while the output is ready.
// Output back-pressure stretches the load step; one item is in work at a time.
// Reset clears pointers, count and control; the ring RAM is not cleared.
`timescale 1ns / 1ps
module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_out
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] now_empty
  output logic        m_axis_tlast
);

  deq_pkg::ctl_cmd_t cmd;
  deq_pkg::ctl_sts_t sts;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op_in      (s_axis_tuser),
    .value_in   (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser[1:0]),
    .out_value  (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_empty  (m_axis_tuser[2])
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded over an untaken beat");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] == deq_pkg::STATUS_FULL) |->
      (!m_axis_tuser[2] && m_axis_tlast && m_axis_tdata == '0))
    else $error("full status with bad companion fields");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] == deq_pkg::STATUS_EMPTY) |->
      (m_axis_tuser[2] && m_axis_tlast && m_axis_tdata == '0))
    else $error("empty status with bad companion fields");

endmodule
